@@ rtl/xmodem_crc_receiver_top_assert.svh @@
// Assertion macros for the XMODEM receiver top level.
// Included by xmodem_crc_receiver_top.sv; needs clock and reset in scope.
`ifndef XMODEM_CRC_RECEIVER_TOP_ASSERT_SVH
`define XMODEM_CRC_RECEIVER_TOP_ASSERT_SVH
// Asserts that a condition implies another one in the same cycle.
`define XR_ASSERT_IMPLY(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("xmodem receiver check failed");
// Asserts that a condition implies another one in the next cycle.
`define XR_ASSERT_NEXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("xmodem receiver check failed");
`endif

@@ rtl/xmr_pkg.sv @@
// Shared types and constants of the XMODEM receiver.
// No dependencies; imported by all receiver modules.
package xmr_pkg;
   localparam int TimerWidth = 16;
   localparam int QueueDepth = 4;
   localparam int QueueAw = 2;

   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_C = 8'h43;

   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   localparam logic [1:0] CSR_TPS = 2'd0;
   localparam logic [1:0] CSR_RETRANS = 2'd1;
   localparam logic [1:0] CSR_RETRY = 2'd2;
   localparam logic [1:0] CSR_CRC = 2'd3;

   localparam logic [1:0] VERDICT_NONE = 2'd0;
   localparam logic [1:0] VERDICT_COMMIT = 2'd1;
   localparam logic [1:0] VERDICT_DISCARD = 2'd2;

   localparam logic [1:0] FIN_EOS = 2'd0;
   localparam logic [1:0] FIN_CANCEL = 2'd1;
   localparam logic [1:0] FIN_ERROR = 2'd2;

   localparam logic [1:0] RESUME_RETRY = 2'd0;
   localparam logic [1:0] RESUME_CANCEL = 2'd1;
   localparam logic [1:0] RESUME_ERROR = 2'd2;

   // One result of the protocol engine.
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [1:0] packet_verdict;
      logic [7:0] block_number;
      logic       finished;
      logic [1:0] finish_code;
      logic       busy_res;
      logic       last;
   } result_type;

   // One classified input entry kept in the queue.
   typedef struct packed {
      logic       is_byte;
      logic       is_tick;
      logic       is_start;
      logic [7:0] data;
   } cmd_type;

   // Queue status between front and back.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   typedef enum logic [8:0] {
      PH_IDLE    = 9'b000000001,
      PH_HEADER  = 9'b000000010,
      PH_BLK     = 9'b000000100,
      PH_CMP     = 9'b000001000,
      PH_PAYLOAD = 9'b000010000,
      PH_TRHI    = 9'b000100000,
      PH_TRLO    = 9'b001000000,
      PH_DELAY   = 9'b010000000,
      PH_FLUSH   = 9'b100000000
   } phase_type;

   // One byte step of CRC-16, polynomial 0x1021.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction
endpackage

@@ rtl/xmodem_crc_receiver_top.sv @@
// XMODEM receiver (128-byte and 1K blocks, CRC-16 or checksum). Each input
// transfer is a line byte, a timer tick or a start command; the front queue
// (four entries) accepts one transfer per cycle unless full and the engine
// consumes one per cycle, producing zero to three results that leave one per
// cycle from a result buffer unless stalled. Sustained rate is one input per
// cycle for inputs with at most one result and no stall; an input with more
// results holds the engine until its last is taken. Timeouts follow configuration
// writes once registered. Depends on xmr_pkg, xmr_front, xmr_back and the assertion header.
`include "xmodem_crc_receiver_top_assert.svh"
module xmodem_crc_receiver_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_data_valid,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_packet_verdict,
   output logic [7:0] rsp_block_number,
   output logic       rsp_finished,
   output logic [1:0] rsp_finish_code,
   output logic       rsp_busy_res,
   output logic       rsp_last,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_wdata
);
   import xmr_pkg::*;

   logic [9:0]  tps_ff;
   logic [7:0]  retrans_ff;
   logic [3:0]  retry_ff;
   logic        crc_ff;
   qhead_type   head;
   logic        pop;
   result_type  rsp;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= 10'd60; retrans_ff <= 8'd25; retry_ff <= 4'd5; crc_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TPS: tps_ff <= csr_wdata;
            CSR_RETRANS: retrans_ff <= csr_wdata[7:0];
            CSR_RETRY: retry_ff <= csr_wdata[3:0];
            CSR_CRC: crc_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   xmr_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_mode, .req_rx_byte, .pop, .head
   );

   xmr_back u_back (
      .clock, .reset, .head, .pop, .tps(tps_ff), .max_retrans(retrans_ff),
      .max_retry(retry_ff), .use_crc(crc_ff), .rsp_valid, .rsp_stall, .rsp
   );

   assign rsp_tx_valid = rsp.tx_valid;
   assign rsp_tx_byte = rsp.tx_byte;
   assign rsp_data_valid = rsp.data_valid;
   assign rsp_data_byte = rsp.data_byte;
   assign rsp_packet_verdict = rsp.packet_verdict;
   assign rsp_block_number = rsp.block_number;
   assign rsp_finished = rsp.finished;
   assign rsp_finish_code = rsp.finish_code;
   assign rsp_busy_res = rsp.busy_res;
   assign rsp_last = rsp.last;

   // A finished transfer is never reported busy.
   `XR_ASSERT_IMPLY(a_fin_idle, rsp_valid && rsp_finished, !rsp_busy_res && rsp_last)
   // A stalled result holds until taken.
   `XR_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_tx_byte))
   // Engine only consumes when an entry is queued.
   `XR_ASSERT_IMPLY(a_pop, pop, head.valid)
endmodule

@@ rtl/xmr_front.sv @@
// Front part: accepts input transfers, drops quiet modes and queues the rest.
// Depends on xmr_pkg.
module xmr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_rx_byte,
   input  logic              pop,
   output xmr_pkg::qhead_type head
);
   import xmr_pkg::*;

   cmd_type                  mem_ff [QueueDepth];
   logic [QueueAw-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueAw:0]         cnt_ff, cnt_in;
   logic                     push;
   cmd_type                  cmd;

   // Classify the incoming item; mode 3 is dropped.
   always_comb begin
      cmd.is_byte = (req_mode == MODE_BYTE);
      cmd.is_tick = (req_mode == MODE_TICK);
      cmd.is_start = (req_mode == MODE_START);
      cmd.data = req_rx_byte;
   end

   assign req_stall = (cnt_ff == QueueAw'(0) + (QueueAw+1)'(QueueDepth));
   assign push = req_valid && !req_stall
                 && (cmd.is_byte || cmd.is_tick || cmd.is_start);

   // Queue pointers.
   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= cmd;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.cmd = mem_ff[rd_ff];
endmodule

@@ rtl/xmr_back.sv @@
// Back part: the protocol engine, one queued input per cycle while the result
// buffer is free, up to three results each, delivered from it. Depends on xmr_pkg.
module xmr_back (
   input  logic                clock,
   input  logic                reset,
   input  xmr_pkg::qhead_type  head,
   output logic                pop,
   input  logic [9:0]          tps,
   input  logic [7:0]          max_retrans,
   input  logic [3:0]          max_retry,
   input  logic                use_crc,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output xmr_pkg::result_type rsp
);
   import xmr_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [7:0]             exp_ff, exp_in, rtl_ff, rtl_in, blk_ff, blk_in;
   logic [7:0]             cmp_ff, cmp_in, thi_ff, thi_in, sum_ff, sum_in;
   logic [3:0]             retry_ff, retry_in;
   logic [10:0]            idx_ff, idx_in;
   logic                   large_ff, large_in;
   logic [15:0]            crc_ff, crc_in;
   logic [TimerWidth-1:0]  tmr_ff, tmr_in;
   logic [1:0]             res_ff, res_in;
   logic [TimerWidth-1:0]  d1, d15, d4, d10;
   result_type             r_ff [3], r_in [3];
   logic [1:0]             n_ff, n_in, k_ff, k_in;
   logic [1:0]             cnt;
   logic                   busy_now;
   logic [7:0]             b;
   logic                   ok, trailer_ok;

   // Durations in ticks: ticks_per_second times tenths over ten.
   function automatic logic [TimerWidth-1:0] dur(input logic [9:0] t, input int tenths);
      logic [13:0] p;
      logic [TimerWidth-1:0] q;
      p = 14'(t * tenths);
      q = TimerWidth'((32'(p) * 32'd6554) >> 16);
      if (32'(q) * 10 > 32'(p)) begin
         q = q - 1'b1;
      end
      return q;
   endfunction

   always_ff @(posedge clock) begin
      d1 <= TimerWidth'(tps);
      d15 <= dur(tps, 15);
      d4 <= TimerWidth'({tps, 2'b00});
      d10 <= TimerWidth'({tps, 3'b000}) + TimerWidth'({tps, 1'b0});
   end

   // The output buffer is free when all results of the last input are taken.
   assign pop = head.valid && (n_ff == '0 || (k_ff == n_ff - 1'b1 && !rsp_stall));
   assign b = head.cmd.data;

   function automatic result_type mk(input logic [7:0] tx, input logic dv,
                                     input logic [7:0] d, input logic [1:0] v,
                                     input logic [7:0] bn, input logic f,
                                     input logic [1:0] fc);
      result_type x;
      x.tx_valid = (tx != 8'h00);
      x.tx_byte = tx;
      x.data_valid = dv;
      x.data_byte = d;
      x.packet_verdict = v;
      x.block_number = bn;
      x.finished = f;
      x.finish_code = fc;
      x.busy_res = 1'b0;
      x.last = 1'b0;
      return x;
   endfunction

   assign trailer_ok = phase_ff == PH_TRLO ? ({thi_ff, b} == crc_ff) : (b == sum_ff);
   assign ok = trailer_ok && blk_ff == ~cmp_ff && blk_ff == exp_ff;

   // Protocol step for the item at the queue head.
   always_comb begin
      phase_in = phase_ff; exp_in = exp_ff; rtl_in = rtl_ff; blk_in = blk_ff;
      cmp_in = cmp_ff; thi_in = thi_ff; sum_in = sum_ff; retry_in = retry_ff;
      idx_in = idx_ff; large_in = large_ff; crc_in = crc_ff; tmr_in = tmr_ff;
      res_in = res_ff;
      r_in[0] = '0; r_in[1] = '0; r_in[2] = '0;
      cnt = 2'd0;
      if (head.cmd.is_start) begin
         exp_in = 8'd1; rtl_in = max_retrans; retry_in = '0;
         phase_in = PH_HEADER; tmr_in = d10;
         r_in[0] = mk(BYTE_C, 1'b0, 8'h00, VERDICT_NONE, 8'h00, 1'b0, FIN_EOS);
         cnt = 2'd1;
      end else if (head.cmd.is_tick) begin
         if (phase_ff == PH_IDLE) begin
         end else if (tmr_ff != '0) begin
            tmr_in = tmr_ff - 1'b1;
         end else begin
            case (phase_ff)
               PH_PAYLOAD, PH_TRHI, PH_TRLO: begin
                  r_in[0] = mk(8'h00, 1'b0, 8'h00, VERDICT_DISCARD, blk_ff, 1'b0, FIN_EOS);
                  cnt = 2'd1; phase_in = PH_DELAY; tmr_in = d4;
               end
               PH_DELAY: begin
                  res_in = RESUME_RETRY; phase_in = PH_FLUSH; tmr_in = d15;
               end
               PH_FLUSH: begin
                  if (res_ff == RESUME_RETRY) begin
                     if (retry_ff >= max_retry) begin
                        res_in = RESUME_ERROR; tmr_in = d15;
                     end else begin
                        retry_in = retry_ff + 1'b1;
                        r_in[0] = mk(BYTE_NAK, 1'b0, 8'h00, VERDICT_NONE, 8'h00, 1'b0,
                                     FIN_EOS);
                        cnt = 2'd1; phase_in = PH_HEADER; tmr_in = d10;
                     end
                  end else if (res_ff == RESUME_CANCEL) begin
                     phase_in = PH_IDLE; tmr_in = '0;
                     r_in[0] = mk(BYTE_ACK, 1'b0, 8'h00, VERDICT_NONE, 8'h00, 1'b1,
                                  FIN_CANCEL);
                     cnt = 2'd1;
                  end else begin
                     phase_in = PH_IDLE; tmr_in = '0;
                     r_in[0] = mk(BYTE_CAN, 1'b0, 8'h00, VERDICT_NONE, 8'h00, 1'b0, FIN_EOS);
                     r_in[1] = r_in[0];
                     r_in[2] = mk(BYTE_CAN, 1'b0, 8'h00, VERDICT_NONE, 8'h00, 1'b1,
                                  FIN_ERROR);
                     cnt = 2'd3;
                  end
               end
               default: begin
                  phase_in = PH_DELAY; tmr_in = d4;
               end
            endcase
         end
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               if (b == BYTE_SOH || b == BYTE_STX) begin
                  large_in = (b == BYTE_STX); phase_in = PH_BLK; tmr_in = d1;
               end else if (b == BYTE_EOT) begin
                  phase_in = PH_IDLE; tmr_in = '0;
                  r_in[0] = mk(BYTE_ACK, 1'b0, 8'h00, VERDICT_NONE, 8'h00, 1'b1, FIN_EOS);
                  cnt = 2'd1;
               end else if (b == BYTE_CAN) begin
                  res_in = RESUME_CANCEL; phase_in = PH_FLUSH; tmr_in = d15;
               end else begin
                  phase_in = PH_DELAY; tmr_in = d4;
               end
            end
            PH_BLK: begin
               blk_in = b; phase_in = PH_CMP; tmr_in = d1;
            end
            PH_CMP: begin
               cmp_in = b; idx_in = '0; crc_in = '0; sum_in = '0;
               phase_in = PH_PAYLOAD; tmr_in = d1;
            end
            PH_PAYLOAD: begin
               r_in[0] = mk(8'h00, 1'b1, b, VERDICT_NONE, 8'h00, 1'b0, FIN_EOS);
               cnt = 2'd1;
               sum_in = sum_ff + b;
               crc_in = crc_step(crc_ff, b);
               idx_in = idx_ff + 1'b1;
               tmr_in = d1;
               phase_in = (idx_in >= (large_ff ? 11'd1024 : 11'd128)) ? PH_TRHI : PH_PAYLOAD;
            end
            PH_TRHI, PH_TRLO: begin
               if (phase_ff == PH_TRHI && use_crc) begin
                  thi_in = b; phase_in = PH_TRLO; tmr_in = d1;
               end else begin
                  cnt = 2'd1;
                  if (ok) begin
                     r_in[0] = mk(BYTE_ACK, 1'b0, 8'h00, VERDICT_COMMIT, blk_ff, 1'b0,
                                  FIN_EOS);
                     exp_in = exp_ff + 1'b1; rtl_in = max_retrans; retry_in = '0;
                     phase_in = PH_HEADER; tmr_in = d10;
                  end else begin
                     r_in[0] = mk(8'h00, 1'b0, 8'h00, VERDICT_DISCARD, blk_ff, 1'b0,
                                  FIN_EOS);
                     if (rtl_ff <= 8'd1) begin
                        rtl_in = '0; res_in = RESUME_ERROR;
                        phase_in = PH_FLUSH; tmr_in = d15;
                     end else begin
                        rtl_in = rtl_ff - 1'b1; phase_in = PH_DELAY; tmr_in = d4;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      busy_now = (phase_in != PH_IDLE);
      for (int i = 0; i < 3; i++) begin
         r_in[i].busy_res = busy_now;
         r_in[i].last = (2'(i) == cnt - 1'b1);
      end
   end

   // Result buffer pointers.
   always_comb begin
      n_in = n_ff; k_in = k_ff;
      if (pop) begin
         n_in = cnt; k_in = '0;
      end else if (n_ff != '0 && !rsp_stall) begin
         if (k_ff == n_ff - 1'b1) begin
            n_in = '0; k_in = '0;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; exp_ff <= 8'd1; rtl_ff <= '0; retry_ff <= '0;
         idx_ff <= '0; large_ff <= 1'b0; crc_ff <= '0; sum_ff <= '0;
         blk_ff <= '0; cmp_ff <= '0; thi_ff <= '0; tmr_ff <= '0; res_ff <= '0;
         n_ff <= '0; k_ff <= '0;
      end else begin
         n_ff <= n_in; k_ff <= k_in;
         if (pop) begin
            phase_ff <= phase_in; exp_ff <= exp_in; rtl_ff <= rtl_in;
            retry_ff <= retry_in; idx_ff <= idx_in; large_ff <= large_in;
            crc_ff <= crc_in; sum_ff <= sum_in; blk_ff <= blk_in; cmp_ff <= cmp_in;
            thi_ff <= thi_in; tmr_ff <= tmr_in; res_ff <= res_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         r_ff[0] <= r_in[0]; r_ff[1] <= r_in[1]; r_ff[2] <= r_in[2];
      end
   end

   assign rsp_valid = (n_ff != '0);
   assign rsp = r_ff[k_ff];
endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the XMODEM receiver top level.
// Depends on xmr_pkg and xmodem_crc_receiver_top; predicts untyped results in-line.
module tb;
   import xmr_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode = MODE_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_byte;
   logic [1:0] rsp_packet_verdict;
   logic [7:0] rsp_block_number;
   logic       rsp_finished;
   logic [1:0] rsp_finish_code;
   logic       rsp_busy_res;
   logic       rsp_last;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = CSR_TPS;
   logic [9:0] csr_wdata = 10'd0;

   xmodem_crc_receiver_top dut (.*);

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver state model.
   logic [9:0]  tps;
   logic [7:0]  cfg_retrans;
   logic [3:0]  cfg_retry;
   logic        cfg_crc;
   phase_type   rx_phase;
   logic [7:0]  next_block;
   logic [7:0]  retrans_left;
   logic [3:0]  retry_count;
   logic [10:0] byte_index;
   logic        big_block;
   logic [15:0] block_crc;
   logic [7:0]  block_sum;
   logic [7:0]  number_byte;
   logic [7:0]  inverse_byte;
   logic [7:0]  crc_high;
   logic [15:0] ticks_left;
   logic [1:0]  resume_act;

   result_type  step_results[$];
   result_type  awaited_q[$];

   int errors = 0;
   int cycle_count = 0;
   int items_sent = 0;
   bit calm = 1'b0;
   bit gaps_on = 1'b1;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   // CRC-16 update over one byte, polynomial 0x1021, MSB first.
   function automatic logic [15:0] crc16_next(logic [15:0] acc, logic [7:0] b);
      logic [15:0] r;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         if (r[15] ^ b[i]) r = {r[14:0], 1'b0} ^ 16'h1021;
         else r = {r[14:0], 1'b0};
      end
      return r;
   endfunction

   // Arms the timer for a number of tenths of a second, saturating.
   function automatic void arm(phase_type p, int tenths);
      int d;
      d = (int'(tps) * tenths) / 10;
      rx_phase = p;
      ticks_left = (d > 65535) ? 16'hFFFF : d[15:0];
   endfunction

   function automatic void add_result(logic [7:0] tx, logic dv, logic [7:0] d,
                                      logic [1:0] verdict, logic [7:0] blk,
                                      logic fin, logic [1:0] code);
      result_type r;
      r = '0;
      r.tx_valid = (tx != 8'h00);
      r.tx_byte = tx;
      r.data_valid = dv;
      r.data_byte = dv ? d : 8'h00;
      r.packet_verdict = verdict;
      r.block_number = (verdict != VERDICT_NONE) ? blk : 8'h00;
      r.finished = fin;
      r.finish_code = fin ? code : FIN_EOS;
      if (step_results.size() < 3) step_results.push_back(r);
   endfunction

   function automatic void judge_block(bit trailer_ok);
      if (trailer_ok && number_byte == ~inverse_byte && number_byte == next_block) begin
         add_result(BYTE_ACK, 0, 0, VERDICT_COMMIT, number_byte, 0, FIN_EOS);
         next_block = next_block + 8'd1;
         retrans_left = cfg_retrans;
         retry_count = 0;
         arm(PH_HEADER, 100);
      end else begin
         add_result(8'h00, 0, 0, VERDICT_DISCARD, number_byte, 0, FIN_EOS);
         if (retrans_left <= 1) begin
            retrans_left = 0;
            resume_act = RESUME_ERROR;
            arm(PH_FLUSH, 15);
         end else begin
            retrans_left = retrans_left - 8'd1;
            arm(PH_DELAY, 40);
         end
      end
   endfunction

   function automatic void tick_event();
      if (rx_phase == PH_IDLE) return;
      if (ticks_left != 0) begin
         ticks_left = ticks_left - 16'd1;
         return;
      end
      case (rx_phase)
         PH_PAYLOAD, PH_TRHI, PH_TRLO: begin
            add_result(8'h00, 0, 0, VERDICT_DISCARD, number_byte, 0, FIN_EOS);
            arm(PH_DELAY, 40);
         end
         PH_DELAY: begin
            resume_act = RESUME_RETRY;
            arm(PH_FLUSH, 15);
         end
         PH_FLUSH: begin
            if (resume_act == RESUME_RETRY) begin
               if (retry_count >= cfg_retry) begin
                  resume_act = RESUME_ERROR;
                  arm(PH_FLUSH, 15);
               end else begin
                  retry_count = retry_count + 4'd1;
                  add_result(BYTE_NAK, 0, 0, VERDICT_NONE, 0, 0, FIN_EOS);
                  arm(PH_HEADER, 100);
               end
            end else if (resume_act == RESUME_CANCEL) begin
               rx_phase = PH_IDLE;
               ticks_left = 0;
               add_result(BYTE_ACK, 0, 0, VERDICT_NONE, 0, 1, FIN_CANCEL);
            end else begin
               rx_phase = PH_IDLE;
               ticks_left = 0;
               add_result(BYTE_CAN, 0, 0, VERDICT_NONE, 0, 0, FIN_EOS);
               add_result(BYTE_CAN, 0, 0, VERDICT_NONE, 0, 0, FIN_EOS);
               add_result(BYTE_CAN, 0, 0, VERDICT_NONE, 0, 1, FIN_ERROR);
            end
         end
         default: arm(PH_DELAY, 40);
      endcase
   endfunction

   function automatic void byte_event(logic [7:0] b);
      case (rx_phase)
         PH_HEADER: begin
            if (b == BYTE_SOH || b == BYTE_STX) begin
               big_block = (b == BYTE_STX);
               arm(PH_BLK, 10);
            end else if (b == BYTE_EOT) begin
               rx_phase = PH_IDLE;
               ticks_left = 0;
               add_result(BYTE_ACK, 0, 0, VERDICT_NONE, 0, 1, FIN_EOS);
            end else if (b == BYTE_CAN) begin
               resume_act = RESUME_CANCEL;
               arm(PH_FLUSH, 15);
            end else begin
               arm(PH_DELAY, 40);
            end
         end
         PH_BLK: begin
            number_byte = b;
            arm(PH_CMP, 10);
         end
         PH_CMP: begin
            inverse_byte = b;
            byte_index = 0;
            block_crc = 0;
            block_sum = 0;
            arm(PH_PAYLOAD, 10);
         end
         PH_PAYLOAD: begin
            add_result(8'h00, 1, b, VERDICT_NONE, 0, 0, FIN_EOS);
            block_sum = block_sum + b;
            block_crc = crc16_next(block_crc, b);
            byte_index = byte_index + 11'd1;
            arm((byte_index >= (big_block ? 11'd1024 : 11'd128)) ? PH_TRHI : PH_PAYLOAD, 10);
         end
         PH_TRHI: begin
            if (cfg_crc) begin
               crc_high = b;
               arm(PH_TRLO, 10);
            end else begin
               judge_block(b == block_sum);
            end
         end
         PH_TRLO: judge_block({crc_high, b} == block_crc);
         default: ;
      endcase
   endfunction

   // Works out the results of one accepted input; typed rows replace them.
   function automatic void predict_input(logic [1:0] mode, logic [7:0] b);
      step_results.delete();
      if (mode == MODE_START) begin
         next_block = 8'd1;
         retrans_left = cfg_retrans;
         retry_count = 0;
         arm(PH_HEADER, 100);
         add_result(BYTE_C, 0, 0, VERDICT_NONE, 0, 0, FIN_EOS);
      end else if (mode == MODE_TICK) begin
         tick_event();
      end else if (mode == MODE_BYTE) begin
         byte_event(b);
      end
   endfunction

   function automatic void queue_results();
      foreach (step_results[k]) begin
         step_results[k].busy_res = (rx_phase != PH_IDLE);
         step_results[k].last = (k == step_results.size() - 1);
         awaited_q.push_back(step_results[k]);
      end
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
               cycle_count, what, got, want);
      errors++;
   endtask

   // Offers one input and waits for its transfer.
   task automatic send(logic [1:0] mode, logic [7:0] b, bit typed = 0,
                       result_type literal = '0);
      if (gaps_on && !calm && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_input(mode, b);
      if (typed) begin
         step_results.delete();
         step_results.push_back(literal);
      end
      queue_results();
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [9:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_TPS: tps = value;
         CSR_RETRANS: cfg_retrans = value[7:0];
         CSR_RETRY: cfg_retry = value[3:0];
         default: cfg_crc = value[0];
      endcase
   endtask

   task automatic setup(logic [9:0] t, logic [7:0] rt, logic [3:0] ry, logic c);
      drain();
      write_reg(CSR_TPS, t);
      write_reg(CSR_RETRANS, {2'b00, rt});
      write_reg(CSR_RETRY, {6'b000000, ry});
      write_reg(CSR_CRC, {9'b000000000, c});
      repeat (4) @(posedge clock);
   endtask

   // Sends one block; flaw 0 is clean, 1 bad trailer, 2 wrong number,
   // 3 bad complement, 4 cut short after up to 12 payload bytes and left to time out.
   task automatic send_block(bit big, int flaw);
      logic [7:0]  num;
      logic [7:0]  d;
      logic [15:0] crc;
      logic [7:0]  sum;
      int size;
      int cut;
      size = big ? 1024 : 128;
      cut = (flaw == 4) ? $urandom_range(0, 12) : size;
      num = (flaw == 2) ? next_block + $urandom_range(1, 255) : next_block;
      crc = 0;
      sum = 0;
      send(MODE_BYTE, big ? BYTE_STX : BYTE_SOH);
      send(MODE_BYTE, num);
      send(MODE_BYTE, (flaw == 3) ? ~num ^ (8'h01 << $urandom_range(0, 7)) : ~num);
      for (int i = 0; i < cut; i++) begin
         d = $urandom_range(0, 255);
         crc = crc16_next(crc, d);
         sum = sum + d;
         send(MODE_BYTE, d);
      end
      if (flaw == 4) begin
         repeat ($urandom_range(1, 12)) send(MODE_TICK, $urandom_range(0, 255));
      end else if (cfg_crc) begin
         if (flaw == 1) crc = crc ^ (16'h1 << $urandom_range(0, 15));
         send(MODE_BYTE, crc[15:8]);
         send(MODE_BYTE, crc[7:0]);
      end else begin
         if (flaw == 1) sum = sum ^ (8'h01 << $urandom_range(0, 7));
         send(MODE_BYTE, sum);
      end
   endtask

   // One random session: a start followed by up to six traffic items while the budget lasts.
   task automatic session(int budget);
      int r;
      send(MODE_START, $urandom_range(0, 255));
      repeat ($urandom_range(1, 6)) begin
         if (items_sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 66) send_block(1'($urandom_range(0, 1)), 4);
            else if (r < 71) send(MODE_BYTE, BYTE_EOT);
            else if (r < 76) begin
               send(MODE_BYTE, BYTE_CAN);
               repeat ($urandom_range(1, 8)) send(MODE_TICK, $urandom_range(0, 255));
            end else if (r < 86) send(MODE_BYTE, $urandom_range(0, 255));
            else if (r < 96) begin
               repeat ($urandom_range(1, 20)) send(MODE_TICK, $urandom_range(0, 255));
            end else if (r < 98) send(MODE_UNUSED, $urandom_range(0, 255));
            else send(MODE_START, $urandom_range(0, 255));
         end
      end
   endtask

   typedef struct {
      logic [1:0] mode;
      logic [7:0] data;
      bit         typed;
      logic [7:0] tx;
      bit         fin;
      logic [1:0] code;
      bit         busy;
   } stim_row_type;

   // Directed part: typed rows carry the one literal result they must produce.
   stim_row_type plan[22] = '{
      '{MODE_BYTE,   8'h55,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_TICK,   8'hFF,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_UNUSED, 8'hAA,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_START,  8'h00,    1, BYTE_C,   0, FIN_EOS,    1},
      '{MODE_BYTE,   BYTE_EOT, 1, BYTE_ACK, 1, FIN_EOS,    0},
      '{MODE_START,  8'hFF,    1, BYTE_C,   0, FIN_EOS,    1},
      '{MODE_BYTE,   BYTE_CAN, 0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_TICK,   8'h00,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_TICK,   8'h00,    1, BYTE_ACK, 1, FIN_CANCEL, 0},
      '{MODE_START,  8'h00,    1, BYTE_C,   0, FIN_EOS,    1},
      '{MODE_BYTE,   BYTE_STX, 0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_BYTE,   8'h01,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_BYTE,   8'hFE,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_BYTE,   8'hFF,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_BYTE,   8'h00,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_TICK,   8'h00,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_TICK,   8'h00,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_BYTE,   8'h00,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_START,  8'h00,    1, BYTE_C,   0, FIN_EOS,    1},
      '{MODE_BYTE,   8'h7E,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_TICK,   8'h00,    0, 8'h00,    0, FIN_EOS,    0},
      '{MODE_START,  8'h00,    1, BYTE_C,   0, FIN_EOS,    1}
   };

   // Stimulus and end of run.
   initial begin
      result_type lit;
      int budget;
      tps = 10'd60;
      cfg_retrans = 8'd25;
      cfg_retry = 4'd5;
      cfg_crc = 1'b1;
      rx_phase = PH_IDLE;
      next_block = 8'd1;
      retrans_left = 0;
      retry_count = 0;
      byte_index = 0;
      big_block = 0;
      block_crc = 0;
      block_sum = 0;
      number_byte = 0;
      inverse_byte = 0;
      crc_high = 0;
      ticks_left = 0;
      resume_act = RESUME_RETRY;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      setup(1, 25, 5, 1);
      foreach (plan[i]) begin
         lit = '0;
         lit.tx_valid = 1'b1;
         lit.tx_byte = plan[i].tx;
         lit.finished = plan[i].fin;
         lit.finish_code = plan[i].code;
         lit.busy_res = plan[i].busy;
         lit.last = 1'b1;
         send(plan[i].mode, plan[i].data, plan[i].typed, lit);
      end
      send_block(0, 0);
      // Random phases over several register settings, extremes included.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: setup(1, 1, 1, 1);
            1: setup(2, 255, 15, 0);
            2: setup(0, 3, 0, 1);
            3: setup(1000, 25, 5, 1);
            4: setup(3, 1, 15, 0);
            default: setup(1, 4, 2, 1);
         endcase
         budget = items_sent + PHASE_ITEMS;
         calm = (p == 4);
         if (p == 1) hold_go <= 1'b1;
         // One full block with a checksum trailer, good or flawed.
         if (p == 4) begin
            send(MODE_START, 8'h00);
            send_block(0, $urandom_range(0, 3));
         end
         while (items_sent < budget) session(budget);
      end
      drain();
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // Result consumer: random stalls, one long hold-off, one calm stretch.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 23);
      end
   end

   // Checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_tx_valid, rsp_tx_byte, rsp_data_valid, rsp_data_byte,
                rsp_packet_verdict, rsp_block_number, rsp_finished,
                rsp_finish_code, rsp_busy_res, rsp_last};
         if (awaited_q.size() == 0) begin
            report("unexpected result", int'(got.tx_byte), 0);
         end else begin
            want = awaited_q.pop_front();
            if (got.tx_valid !== want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
            if (got.tx_byte !== want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
            if (got.data_valid !== want.data_valid)
               report("data_valid", got.data_valid, want.data_valid);
            if (got.data_byte !== want.data_byte)
               report("data_byte", got.data_byte, want.data_byte);
            if (got.packet_verdict !== want.packet_verdict)
               report("packet_verdict", got.packet_verdict, want.packet_verdict);
            if (got.block_number !== want.block_number)
               report("block_number", got.block_number, want.block_number);
            if (got.finished !== want.finished) report("finished", got.finished, want.finished);
            if (got.finish_code !== want.finish_code)
               report("finish_code", got.finish_code, want.finish_code);
            if (got.busy_res !== want.busy_res) report("busy_res", got.busy_res, want.busy_res);
            if (got.last !== want.last) report("last", got.last, want.last);
         end
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/xmr_pkg.sv
rtl/xmr_front.sv
rtl/xmr_back.sv
rtl/xmodem_crc_receiver_top.sv
sim/tb.sv
